### rtl/core/rgbhue_pkg.sv
// Package for the RGB-to-hue pipeline: payload structs, channel codes and
// divider sizing constants. No dependencies; used by every file in rtl/core.
package rgbhue_pkg;

  // Width of one color channel.
  localparam int unsigned ChanW = 8;
  // Width of the hue result (Q0.16 fraction of a full turn).
  localparam int unsigned HueW = 16;
  // Divisor is 6*delta, at most 1530, so 11 bits; remainders stay below it.
  localparam int unsigned DvsW = 11;
  // Quotient bits resolved per divider stage, and the resulting stage count.
  localparam int unsigned DivStepsPerStage = 2;
  localparam int unsigned DivStages = HueW / DivStepsPerStage;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic            achromatic;
  } hue_t;

  // Which channel holds the maximum, with priority red, green, blue.
  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  // Word carried down the divider pipeline.
  typedef struct packed {
    logic [DvsW-1:0] rem;
    logic [DvsW-1:0] dvs;
    logic [HueW-1:0] quo;
    logic            achromatic;
  } div_word_t;

endpackage

### rtl/core/rgbhue_prep.sv
// Front end of the hue pipeline: max/min search, sector choice, then the
// numerator and the 6*delta divisor. Two register stages. Uses rgbhue_pkg.
module rgbhue_prep (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  rgbhue_pkg::pixel_t     up_data,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output rgbhue_pkg::div_word_t  dn_data
);
  import rgbhue_pkg::*;

  // Stage A registers.
  logic             a_valid;
  logic [ChanW-1:0] a_delta;
  logic [ChanW:0]   a_diff;
  chan_t            a_sel;
  logic             a_wrap;
  logic             a_achrom;

  // Stage B registers.
  logic             b_valid;
  div_word_t        b_word;

  logic en_a;
  logic en_b;

  // Stage A combinational values.
  logic [ChanW-1:0] hi;
  logic [ChanW-1:0] lo;
  chan_t            sel;
  logic [ChanW:0]   diff;

  // Stage B combinational values.
  logic [DvsW-1:0]  d6;
  logic [DvsW-1:0]  offs;
  logic [DvsW:0]    sum;

  assign en_b     = !b_valid || dn_ready;
  assign en_a     = !a_valid || en_b;
  assign up_ready = en_a;
  assign dn_valid = b_valid;
  assign dn_data  = b_word;

  always_comb begin
    hi = up_data.red;
    lo = up_data.red;
    if (up_data.green > hi) hi = up_data.green;
    if (up_data.blue > hi) hi = up_data.blue;
    if (up_data.green < lo) lo = up_data.green;
    if (up_data.blue < lo) lo = up_data.blue;
    if (hi == up_data.red) begin
      sel  = CH_RED;
      diff = {1'b0, up_data.green} - {1'b0, up_data.blue};
    end else if (hi == up_data.green) begin
      sel  = CH_GREEN;
      diff = {1'b0, up_data.blue} - {1'b0, up_data.red};
    end else begin
      sel  = CH_BLUE;
      diff = {1'b0, up_data.red} - {1'b0, up_data.green};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_delta  <= hi - lo;
      a_diff   <= diff;
      a_sel    <= sel;
      a_wrap   <= up_data.green < up_data.blue;
      a_achrom <= hi == lo;
    end
  end

  always_comb begin
    d6 = {1'b0, a_delta, 2'b00} + {2'b00, a_delta, 1'b0};
    case (a_sel)
      CH_RED:   offs = a_wrap ? d6 : '0;
      CH_GREEN: offs = {2'b00, a_delta, 1'b0};
      CH_BLUE:  offs = {1'b0, a_delta, 2'b00};
      default:  offs = '0;
    endcase
    // Signed sum of the sector offset and the channel difference.
    sum = {1'b0, offs} + {{(DvsW-ChanW){a_diff[ChanW]}}, a_diff};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_word.rem        <= (sum[DvsW] || a_achrom) ? '0 : sum[DvsW-1:0];
      b_word.dvs        <= d6;
      b_word.quo        <= '0;
      b_word.achromatic <= a_achrom;
    end
  end

endmodule

### rtl/core/rgbhue_div_stage.sv
// One stage of the pipelined restoring divider: resolves two quotient
// bits per item and registers the result. Uses rgbhue_pkg.
module rgbhue_div_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  rgbhue_pkg::div_word_t  up_data,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output rgbhue_pkg::div_word_t  dn_data
);
  import rgbhue_pkg::*;

  logic      valid;
  div_word_t word;
  div_word_t word_next;
  logic      en;

  assign en       = !valid || dn_ready;
  assign up_ready = en;
  assign dn_valid = valid;
  assign dn_data  = word;

  // For chromatic pixels the remainder is always below the divisor, so the doubled value fits
  // one extra bit and a single compare-subtract decides each quotient bit.
  always_comb begin
    logic [DvsW:0] t;
    word_next = up_data;
    for (int i = 0; i < DivStepsPerStage; i++) begin
      t = {word_next.rem, 1'b0};
      if (t >= {1'b0, word_next.dvs}) begin
        t             = t - {1'b0, word_next.dvs};
        word_next.quo = {word_next.quo[HueW-2:0], 1'b1};
      end else begin
        word_next.quo = {word_next.quo[HueW-2:0], 1'b0};
      end
      word_next.rem = t[DvsW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word <= word_next;
    end
  end

endmodule

### rtl/core/rgb8_hue_calculator_unit.sv
// Top level of the RGB-to-hue converter: front end plus divider pipeline.
// Depends on rgbhue_pkg, rgbhue_prep and rgbhue_div_stage.
//
// Usage:
//   Pixels enter on the pix channel (valid/ready, payload pix with fields
//   red, green, blue). Results leave on the res channel (payload res with
//   hue, a Q0.16 fraction of a full turn, and achromatic, set when all
//   three channels are equal, in which case hue is zero).
//   Each pixel passes through two front-end stages (max/min and sector,
//   then numerator and 6*delta divisor) and eight divider stages that
//   each resolve two of the 16 quotient bits. Throughput is one pixel per
//   cycle while res_ready stays high; the divider stage count sets the
//   latency. Results come out in input order, one per pixel.
//   Each stage carries its own valid bit and stalls only when it is full
//   and the stage after it does not move, so while res_ready is low the
//   pipeline keeps taking pixels until every stage holds one; then
//   pix_ready drops. Nothing is lost or repeated under a stall.
//   Reset (rst, synchronous) empties every stage; payload is not cleared.
module rgb8_hue_calculator_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                pix_valid,
  output logic                pix_ready,
  input  rgbhue_pkg::pixel_t  pix,
  output logic                res_valid,
  input  logic                res_ready,
  output rgbhue_pkg::hue_t    res
);
  import rgbhue_pkg::*;

  logic      chain_valid [DivStages+1];
  logic      chain_ready [DivStages+1];
  div_word_t chain_data  [DivStages+1];

  rgbhue_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pix_valid),
    .up_ready (pix_ready),
    .up_data  (pix),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    rgbhue_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[s]),
      .up_ready (chain_ready[s]),
      .up_data  (chain_data[s]),
      .dn_valid (chain_valid[s+1]),
      .dn_ready (chain_ready[s+1]),
      .dn_data  (chain_data[s+1])
    );
  end

  assign chain_ready[DivStages] = res_ready;
  assign res_valid      = chain_valid[DivStages];
  assign res.hue        = chain_data[DivStages].achromatic ? '0 : chain_data[DivStages].quo;
  assign res.achromatic = chain_data[DivStages].achromatic;

  // The numerator entering the divider must stay below the divisor.
  assert property (@(posedge clk) disable iff (rst)
    chain_valid[0] && !chain_data[0].achromatic |-> chain_data[0].rem < chain_data[0].dvs)
    else $error("numerator not below divisor at divider entry");

  // A zero divisor occurs exactly for achromatic pixels.
  assert property (@(posedge clk) disable iff (rst)
    chain_valid[0] |-> (chain_data[0].dvs == '0) == chain_data[0].achromatic)
    else $error("divisor zero does not match achromatic flag");

  // The final remainder stays below the divisor for chromatic pixels.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.achromatic |->
      chain_data[DivStages].rem < chain_data[DivStages].dvs)
    else $error("divider remainder out of range at output");

  // An item stalled at the output is not overwritten by the stage behind it.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(chain_data[DivStages]))
    else $error("output stage changed while stalled");

endmodule
